// ===== rtl/mtse_pkg.sv =====
// Shared types, event codes and helpers for the multi-touch slot event encoder.
package mtse_pkg;

	localparam int MAX_SLOTS = 5;

	// Request codes
	localparam logic REQ_TOUCH   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;

	// Event types
	localparam logic [1:0] EV_SYN = 2'd0;
	localparam logic [1:0] EV_KEY = 2'd1;
	localparam logic [1:0] EV_ABS = 2'd3;

	// Event codes
	localparam logic [9:0] CODE_SYN      = 10'd0;
	localparam logic [9:0] CODE_ABS_X    = 10'd0;
	localparam logic [9:0] CODE_ABS_Y    = 10'd1;
	localparam logic [9:0] CODE_SLOT     = 10'd47;
	localparam logic [9:0] CODE_POS_X    = 10'd53;
	localparam logic [9:0] CODE_POS_Y    = 10'd54;
	localparam logic [9:0] CODE_TRACK    = 10'd57;
	localparam logic [9:0] CODE_PRESS    = 10'd58;
	localparam logic [9:0] CODE_K_FINGER = 10'd325;
	localparam logic [9:0] CODE_K_QUINT  = 10'd328;
	localparam logic [9:0] CODE_K_TOUCH  = 10'd330;
	localparam logic [9:0] CODE_K_DOUBLE = 10'd333;
	localparam logic [9:0] CODE_K_TRIPLE = 10'd334;
	localparam logic [9:0] CODE_K_QUAD   = 10'd335;

	localparam logic [16:0] VAL_NEG_ONE = 17'h1FFFF;
	localparam logic [15:0] ABS_FULL    = 16'hFFFF;

	typedef enum logic [1:0] {
		K_NEW     = 2'd0,
		K_MOVE    = 2'd1,
		K_LIFT    = 2'd2,
		K_REL_ALL = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [2:0]             slot;
		logic [15:0]            x;
		logic [15:0]            y;
		logic [15:0]            press;
		logic [MAX_SLOTS-1:0]   mask;
		logic [9:0]             tool_a;
		logic [9:0]             tool_b;
		logic                   tool_vld;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  etype;
		logic [9:0]  code;
		logic [16:0] value;
		logic        last;
	} ev_t;

	// Tool key for a finger count; anything outside 1..4 maps to quint-tap
	function automatic logic [9:0] tool_code(input logic [2:0] cnt);
		logic [9:0] c;
		case (cnt)
			3'd1: c = CODE_K_FINGER;
			3'd2: c = CODE_K_DOUBLE;
			3'd3: c = CODE_K_TRIPLE;
			3'd4: c = CODE_K_QUAD;
			default: c = CODE_K_QUINT;
		endcase
		return c;
	endfunction

	function automatic ev_t make_ev(input logic [1:0] t, input logic [9:0] c,
			input logic [16:0] v, input logic l);
		ev_t e;
		e.etype = t;
		e.code  = c;
		e.value = v;
		e.last  = l;
		return e;
	endfunction

endpackage

// ===== rtl/mtse_fifo.sv =====
// Small register queue with full and empty flags.
module mtse_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/mtse_div.sv =====
// Serial coordinate scaler: floor(v*65535/size), saturated, one quotient bit per cycle.
module mtse_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] coord,
	input  logic [15:0] size,
	output logic        done,
	output logic [15:0] quot
);
	import mtse_pkg::*;

	logic        busy_q, done_q;
	logic [3:0]  cnt_q;
	logic [15:0] rem_q, lo_q, div_q;
	logic [31:0] prod;
	logic [16:0] trial, diff;
	logic        qbit;
	logic        sat;

	// v*65535 as v*2^16 - v
	assign prod  = {coord, 16'h0000} - {16'h0000, coord};
	// v >= size means the quotient reaches full scale
	assign sat   = (size == 16'h0000) || (coord >= size);
	assign trial = {rem_q, lo_q[15]};
	assign diff  = trial - {1'b0, div_q};
	assign qbit  = (trial >= {1'b0, div_q});

	assign done = done_q;
	assign quot = lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !sat;
			done_q <= sat;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 4'hF) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= size;
			if (sat) begin
				lo_q <= ABS_FULL;
			end else begin
				rem_q <= prod[31:16];
				lo_q  <= prod[15:0];
			end
		end else if (busy_q) begin
			rem_q <= qbit ? diff[15:0] : trial[15:0];
			lo_q  <= {lo_q[14:0], qbit};
		end
	end

endmodule

// ===== rtl/mtse_front.sv =====
// Front end: takes requests, classifies them against the slot flags, queues commands.
module mtse_front #(
	parameter int NUM_SLOTS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              req_type,
	input  logic [15:0]       touch_x,
	input  logic [15:0]       touch_y,
	input  logic [2:0]        slot_index,
	input  logic              finger_down,
	input  logic [15:0]       pressure_level,
	input  logic              cmd_full,
	output logic              cmd_push,
	output mtse_pkg::cmd_t    cmd_data
);
	import mtse_pkg::*;

	localparam logic [2:0] SLOT_LIM = 3'(NUM_SLOTS);

	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] sel;
	logic                 accept, slot_ok, was_act;
	logic [2:0]           cnt_new, cnt_old;

	assign accept   = push && !cmd_full;
	assign slot_ok  = (slot_index < SLOT_LIM);
	assign sel      = slot_ok ? ({{(NUM_SLOTS-1){1'b0}}, 1'b1} << slot_index) : '0;
	assign was_act  = |(active_q & sel);
	assign cnt_new  = 3'($countones(active_q | sel));
	assign cnt_old  = 3'($countones(active_q));
	// out-of-range slots on a touch report are dropped here
	assign cmd_push = accept && ((req_type == REQ_RELEASE) || slot_ok);

	always_comb begin
		cmd_data          = '0;
		cmd_data.slot     = slot_index;
		cmd_data.x        = touch_x;
		cmd_data.y        = touch_y;
		cmd_data.press    = pressure_level;
		cmd_data.mask[NUM_SLOTS-1:0] = active_q;
		if (req_type == REQ_RELEASE) begin
			cmd_data.kind = K_REL_ALL;
		end else if (finger_down && !was_act) begin
			cmd_data.kind   = K_NEW;
			cmd_data.tool_a = tool_code(cnt_new - 3'd1);
			cmd_data.tool_b = tool_code(cnt_new);
		end else if (finger_down) begin
			cmd_data.kind = K_MOVE;
		end else begin
			// lift counts the slot as it was before the lift
			cmd_data.kind     = K_LIFT;
			cmd_data.tool_a   = tool_code(cnt_old);
			cmd_data.tool_vld = (cnt_old >= 3'd2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd_push) begin
			case (cmd_data.kind)
				K_REL_ALL: active_q <= '0;
				K_NEW:     active_q <= active_q | sel;
				K_LIFT:    active_q <= active_q & ~sel;
				default:   active_q <= active_q;
			endcase
		end
	end

endmodule

// ===== rtl/mtse_back.sv =====
// Back end: walks each command's event run, scales coordinates, feeds the result queue.
module mtse_back #(
	parameter int NUM_SLOTS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  mtse_pkg::cmd_t cmd_data,
	output logic           cmd_pop,
	input  logic [15:0]    scr_w,
	input  logic [15:0]    scr_h,
	input  logic           out_full,
	output logic           ev_push,
	output mtse_pkg::ev_t  ev_data
);
	import mtse_pkg::*;

	localparam logic [2:0] LAST_PTR = 3'(NUM_SLOTS - 1);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_REL  = 3'b010,
		B_SEQ  = 3'b100
	} bstate_t;

	bstate_t     state_q;
	logic [3:0]  step_q;
	logic [2:0]  ptr_q;
	logic        half_q;
	cmd_t        cmd_q;

	logic        div_start, x_done, y_done;
	logic [15:0] ax, ay;
	ev_t         seq_ev, rel_ev;
	logic        need_div, seq_go, rel_go, rel_hit;
	logic [16:0] slot_val, press_val, ax_val, ay_val;

	assign cmd_pop   = (state_q == B_IDLE) && !cmd_empty;
	assign div_start = cmd_pop && ((cmd_data.kind == K_NEW) || (cmd_data.kind == K_MOVE));

	mtse_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.coord  (cmd_data.x),
		.size   (scr_w),
		.done   (x_done),
		.quot   (ax)
	);

	mtse_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.coord  (cmd_data.y),
		.size   (scr_h),
		.done   (y_done),
		.quot   (ay)
	);

	assign slot_val  = {14'h0000, cmd_q.slot};
	assign press_val = {1'b0, cmd_q.press};
	assign ax_val    = {1'b0, ax};
	assign ay_val    = {1'b0, ay};

	// release-all: slot select then tracking id -1 for each active slot
	assign rel_hit = cmd_q.mask[ptr_q];
	assign rel_ev  = half_q ? make_ev(EV_ABS, CODE_TRACK, VAL_NEG_ONE, 1'b0)
	                        : make_ev(EV_ABS, CODE_SLOT, {14'h0000, ptr_q}, 1'b0);
	assign rel_go  = (state_q == B_REL) && rel_hit && !out_full;

	always_comb begin
		seq_ev   = make_ev(EV_SYN, CODE_SYN, 17'h00000, 1'b1);
		need_div = 1'b0;
		case (cmd_q.kind)
			K_NEW: begin
				case (step_q)
					4'd0: seq_ev = make_ev(EV_ABS, CODE_SLOT, slot_val, 1'b0);
					4'd1: seq_ev = make_ev(EV_ABS, CODE_TRACK, slot_val, 1'b0);
					4'd2: seq_ev = make_ev(EV_KEY, CODE_K_TOUCH, 17'h00001, 1'b0);
					4'd3: seq_ev = make_ev(EV_KEY, cmd_q.tool_a, 17'h00000, 1'b0);
					4'd4: seq_ev = make_ev(EV_KEY, cmd_q.tool_b, 17'h00001, 1'b0);
					4'd5: seq_ev = make_ev(EV_ABS, CODE_PRESS, press_val, 1'b0);
					4'd6: begin
						seq_ev   = make_ev(EV_ABS, CODE_POS_X, ax_val, 1'b0);
						need_div = 1'b1;
					end
					4'd7: seq_ev = make_ev(EV_ABS, CODE_POS_Y, ay_val, 1'b0);
					4'd8: seq_ev = make_ev(EV_ABS, CODE_ABS_X, ax_val, 1'b0);
					4'd9: seq_ev = make_ev(EV_ABS, CODE_ABS_Y, ay_val, 1'b0);
					default: seq_ev = make_ev(EV_SYN, CODE_SYN, 17'h00000, 1'b1);
				endcase
			end
			K_MOVE: begin
				case (step_q)
					4'd0: seq_ev = make_ev(EV_ABS, CODE_SLOT, slot_val, 1'b0);
					4'd1: seq_ev = make_ev(EV_ABS, CODE_PRESS, press_val, 1'b0);
					4'd2: begin
						seq_ev   = make_ev(EV_ABS, CODE_POS_X, ax_val, 1'b0);
						need_div = 1'b1;
					end
					4'd3: seq_ev = make_ev(EV_ABS, CODE_POS_Y, ay_val, 1'b0);
					4'd4: seq_ev = make_ev(EV_ABS, CODE_ABS_X, ax_val, 1'b0);
					4'd5: seq_ev = make_ev(EV_ABS, CODE_ABS_Y, ay_val, 1'b0);
					default: seq_ev = make_ev(EV_SYN, CODE_SYN, 17'h00000, 1'b1);
				endcase
			end
			K_LIFT: begin
				case (step_q)
					4'd0: seq_ev = make_ev(EV_ABS, CODE_SLOT, slot_val, 1'b0);
					4'd1: seq_ev = make_ev(EV_ABS, CODE_TRACK, VAL_NEG_ONE, 1'b0);
					4'd2: seq_ev = make_ev(EV_KEY, CODE_K_TOUCH, 17'h00000, 1'b0);
					4'd3: seq_ev = make_ev(EV_KEY, CODE_K_FINGER, 17'h00000, 1'b0);
					4'd4: begin
						// extra tool key only when two or more slots were down
						if (cmd_q.tool_vld) begin
							seq_ev = make_ev(EV_KEY, cmd_q.tool_a, 17'h00000, 1'b0);
						end
					end
					default: seq_ev = make_ev(EV_SYN, CODE_SYN, 17'h00000, 1'b1);
				endcase
			end
			K_REL_ALL: begin
				case (step_q)
					4'd0: seq_ev = make_ev(EV_KEY, CODE_K_TOUCH, 17'h00000, 1'b0);
					4'd1: seq_ev = make_ev(EV_KEY, CODE_K_FINGER, 17'h00000, 1'b0);
					4'd2: seq_ev = make_ev(EV_KEY, CODE_K_DOUBLE, 17'h00000, 1'b0);
					4'd3: seq_ev = make_ev(EV_KEY, CODE_K_TRIPLE, 17'h00000, 1'b0);
					4'd4: seq_ev = make_ev(EV_KEY, CODE_K_QUAD, 17'h00000, 1'b0);
					4'd5: seq_ev = make_ev(EV_KEY, CODE_K_QUINT, 17'h00000, 1'b0);
					default: seq_ev = make_ev(EV_SYN, CODE_SYN, 17'h00000, 1'b1);
				endcase
			end
			default: seq_ev = make_ev(EV_SYN, CODE_SYN, 17'h00000, 1'b1);
		endcase
	end

	// hold on a position beat until both scalers are done
	assign seq_go  = (state_q == B_SEQ) && !out_full && (!need_div || (x_done && y_done));
	assign ev_push = rel_go || seq_go;
	assign ev_data = (state_q == B_REL) ? rel_ev : seq_ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
			ptr_q   <= '0;
			half_q  <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (cmd_pop) begin
						step_q  <= '0;
						ptr_q   <= '0;
						half_q  <= 1'b0;
						state_q <= (cmd_data.kind == K_REL_ALL) ? B_REL : B_SEQ;
					end
				end
				B_REL: begin
					if (!rel_hit || (rel_go && half_q)) begin
						half_q <= 1'b0;
						if (ptr_q == LAST_PTR) begin
							state_q <= B_SEQ;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end else if (rel_go) begin
						half_q <= 1'b1;
					end
				end
				B_SEQ: begin
					if (seq_go) begin
						if (seq_ev.last) begin
							state_q <= B_IDLE;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_data;
		end
	end

endmodule

// ===== rtl/multitouch_slot_event_encoder.sv =====
// Multi-touch slot event encoder top level: config registers, queues, front and back.
//
// Requests enter on push/full: an item is taken when push is high and full is low.
// Each touch report for a slot below NUM_SLOTS, and each release-all, turns into a
// run of input events (type, code, value) read out on empty/pop; the closing sync
// event carries last_event. Reports for higher slots give no events at all.
// Screen width and height are written through cfg_valid/cfg_ready (always ready),
// cfg_index 0 for width and 1 for height; other indexes are ignored.
// The front classifies a request in its accept cycle against the per-slot active
// flags and drops a command into a short queue, so it keeps taking requests while
// the back works. The first event passes the command queue, the back's command
// register and the result queue before it shows on the outputs. The back emits a
// run's events one at a time and pops the next command only once the run is done.
// Position events wait on two 16-step serial dividers started when the command is
// loaded; a divider whose coordinate saturates skips the steps.
// When the receiver stops popping, the result queue fills and the back holds; the
// command queue then fills and full rises. Reset clears all slot flags, empties
// both queues and loads 1920 by 1080.
module multitouch_slot_event_encoder #(
	parameter int NUM_SLOTS = 5,
	parameter int CMD_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               req_type,
	input  logic [15:0]        touch_x,
	input  logic [15:0]        touch_y,
	input  logic [2:0]         slot_index,
	input  logic               finger_down,
	input  logic [15:0]        pressure_level,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         event_type,
	output logic [9:0]         event_code,
	output logic signed [16:0] event_value,
	output logic               last_event,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import mtse_pkg::*;

	logic [15:0] scr_w_q, scr_h_q;
	logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
	cmd_t        cmd_in, cmd_out;
	logic        ev_push, out_full;
	ev_t         ev_in, ev_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= 16'd1920;
			scr_h_q <= 16'd1080;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  scr_w_q <= cfg_data;
				CFG_HEIGHT: scr_h_q <= cfg_data;
				default:    scr_w_q <= scr_w_q;
			endcase
		end
	end

	mtse_front #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.req_type       (req_type),
		.touch_x        (touch_x),
		.touch_y        (touch_y),
		.slot_index     (slot_index),
		.finger_down    (finger_down),
		.pressure_level (pressure_level),
		.cmd_full       (cmd_full),
		.cmd_push       (cmd_push),
		.cmd_data       (cmd_in)
	);

	assign full = cmd_full;

	mtse_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	mtse_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_data  (cmd_out),
		.cmd_pop   (cmd_pop),
		.scr_w     (scr_w_q),
		.scr_h     (scr_h_q),
		.out_full  (out_full),
		.ev_push   (ev_push),
		.ev_data   (ev_in)
	);

	mtse_fifo #(
		.WIDTH ($bits(ev_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ev_push),
		.wr_data (ev_in),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (ev_out),
		.empty   (empty)
	);

	assign event_type  = ev_out.etype;
	assign event_code  = ev_out.code;
	assign event_value = ev_out.value;
	assign last_event  = ev_out.last;

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(ev_push && out_full))
		else $error("event written into a full result queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_pop && cmd_empty))
		else $error("command taken from an empty queue");

	a_last_is_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last_event) |-> (event_type == EV_SYN && event_code == CODE_SYN))
		else $error("run closed by an event other than sync");

	a_drop_bad_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && req_type == REQ_TOUCH && slot_index >= 3'(NUM_SLOTS))
			|-> !cmd_push)
		else $error("out-of-range slot produced a command");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the multi-touch slot event encoder.
`timescale 1ns / 100ps

module tb;
	import mtse_pkg::*;

	localparam int SLOTS       = 5;
	localparam int SETTLE      = 40;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 64;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic        req;
		logic [15:0] x;
		logic [15:0] y;
		logic [2:0]  slot;
		logic        down;
		logic [15:0] press;
	} touch_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = CFG_WIDTH;
	logic [15:0] cfg_data = 16'd0;
	touch_req_t cur_req = '0;

	logic full, empty, last_event, cfg_ready;
	logic [1:0] event_type;
	logic [9:0] event_code;
	logic signed [16:0] event_value;

	touch_req_t pending_reqs[$];
	ev_t expected_events[$];

	// predictor state
	logic [SLOTS-1:0] slot_live = '0;
	logic [15:0] scr_w = 16'd1920;
	logic [15:0] scr_h = 16'd1080;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_cnt = 0;

	multitouch_slot_event_encoder #(.NUM_SLOTS(SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(cur_req.req),
		.touch_x(cur_req.x),
		.touch_y(cur_req.y),
		.slot_index(cur_req.slot),
		.finger_down(cur_req.down),
		.pressure_level(cur_req.press),
		.empty(empty),
		.pop(pop),
		.event_type(event_type),
		.event_code(event_code),
		.event_value(event_value),
		.last_event(last_event),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [9:0] finger_key(input int n);
		case (n)
			1: return CODE_K_FINGER;
			2: return CODE_K_DOUBLE;
			3: return CODE_K_TRIPLE;
			4: return CODE_K_QUAD;
			default: return CODE_K_QUINT;
		endcase
	endfunction

	function automatic logic [15:0] scale_coord(input logic [15:0] v, input logic [15:0] size);
		logic [31:0] q;
		if (size == 16'd0)
			return ABS_FULL;
		q = (32'(v) * 32'd65535) / 32'(size);
		return (q > 32'd65535) ? ABS_FULL : q[15:0];
	endfunction

	task automatic add_event(input logic [1:0] t, input logic [9:0] c, input logic [16:0] v,
			input logic l);
		ev_t e;
		e.etype = t;
		e.code  = c;
		e.value = v;
		e.last  = l;
		expected_events.push_back(e);
	endtask

	// Work out the event run that one accepted request causes.
	task automatic predict_run(input touch_req_t r);
		int n;
		logic [15:0] ax, ay;
		if (r.req == REQ_RELEASE) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_live[i]) begin
					add_event(EV_ABS, CODE_SLOT, 17'(i), 1'b0);
					add_event(EV_ABS, CODE_TRACK, VAL_NEG_ONE, 1'b0);
				end
			end
			slot_live = '0;
			add_event(EV_KEY, CODE_K_TOUCH, 17'd0, 1'b0);
			add_event(EV_KEY, CODE_K_FINGER, 17'd0, 1'b0);
			add_event(EV_KEY, CODE_K_DOUBLE, 17'd0, 1'b0);
			add_event(EV_KEY, CODE_K_TRIPLE, 17'd0, 1'b0);
			add_event(EV_KEY, CODE_K_QUAD, 17'd0, 1'b0);
			add_event(EV_KEY, CODE_K_QUINT, 17'd0, 1'b0);
			add_event(EV_SYN, CODE_SYN, 17'd0, 1'b1);
			return;
		end
		// out-of-range slot: drop silently
		if (r.slot >= SLOTS)
			return;
		add_event(EV_ABS, CODE_SLOT, 17'(r.slot), 1'b0);
		if (r.down) begin
			ax = scale_coord(r.x, scr_w);
			ay = scale_coord(r.y, scr_h);
			if (!slot_live[r.slot]) begin
				slot_live[r.slot] = 1'b1;
				n = $countones(slot_live);
				add_event(EV_ABS, CODE_TRACK, 17'(r.slot), 1'b0);
				add_event(EV_KEY, CODE_K_TOUCH, 17'd1, 1'b0);
				// count of one clears quint-tap, since the key table has no entry for zero
				add_event(EV_KEY, finger_key(n - 1), 17'd0, 1'b0);
				add_event(EV_KEY, finger_key(n), 17'd1, 1'b0);
			end
			add_event(EV_ABS, CODE_PRESS, {1'b0, r.press}, 1'b0);
			add_event(EV_ABS, CODE_POS_X, {1'b0, ax}, 1'b0);
			add_event(EV_ABS, CODE_POS_Y, {1'b0, ay}, 1'b0);
			add_event(EV_ABS, CODE_ABS_X, {1'b0, ax}, 1'b0);
			add_event(EV_ABS, CODE_ABS_Y, {1'b0, ay}, 1'b0);
		end else begin
			n = $countones(slot_live);
			add_event(EV_ABS, CODE_TRACK, VAL_NEG_ONE, 1'b0);
			add_event(EV_KEY, CODE_K_TOUCH, 17'd0, 1'b0);
			add_event(EV_KEY, CODE_K_FINGER, 17'd0, 1'b0);
			if (n >= 2 && n <= 5)
				add_event(EV_KEY, finger_key(n), 17'd0, 1'b0);
			slot_live[r.slot] = 1'b0;
		end
		add_event(EV_SYN, CODE_SYN, 17'd0, 1'b1);
	endtask

	// Driver: present the next request, hold it until the beat is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				predict_run(cur_req);
			if (!push || !full) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req <= pending_reqs.pop_front();
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each popped beat with the oldest expected event.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_events.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: unexpected event type=%0d code=%0d value=%h last=%0b",
							$realtime, event_type, event_code, event_value, last_event);
					mismatch_cnt++;
				end else if (event_type !== expected_events[0].etype ||
						event_code !== expected_events[0].code ||
						event_value !== expected_events[0].value ||
						last_event !== expected_events[0].last) begin
					if (mismatch_cnt < 10)
						$display("%0t: event mismatch exp %0d/%0d/%h/%0b got %0d/%0d/%h/%0b",
							$realtime, expected_events[0].etype, expected_events[0].code,
							expected_events[0].value, expected_events[0].last,
							event_type, event_code, event_value, last_event);
					mismatch_cnt++;
					void'(expected_events.pop_front());
				end else begin
					void'(expected_events.pop_front());
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic add_req(input logic req, input logic [2:0] slot, input logic down,
			input logic [15:0] x, input logic [15:0] y, input logic [15:0] press);
		touch_req_t r;
		r.req   = req;
		r.slot  = slot;
		r.down  = down;
		r.x     = x;
		r.y     = y;
		r.press = press;
		pending_reqs.push_back(r);
	endtask

	function automatic touch_req_t random_req();
		touch_req_t r;
		int pick;
		r.req   = REQ_TOUCH;
		r.x     = 16'($urandom);
		r.y     = 16'($urandom);
		r.press = 16'($urandom);
		r.slot  = 3'($urandom_range(0, SLOTS - 1));
		r.down  = 1'b1;
		pick = $urandom_range(99);
		if (pick < 6) begin
			r.req  = REQ_RELEASE;
			r.slot = 3'($urandom);
			r.down = 1'($urandom);
		end else if (pick < 11) begin
			r.slot = 3'($urandom_range(SLOTS, 7));
			r.down = 1'($urandom);
		end else if (pick < 30) begin
			r.down = 1'b0;
		end else if ($urandom_range(1) == 1) begin
			// keep the contact on screen
			r.x = 16'($urandom_range(0, scr_w));
			r.y = 16'($urandom_range(0, scr_h));
		end
		return r;
	endfunction

	// Hold valid high across back-to-back writes; the caller lowers it.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_WIDTH)
			scr_w = val;
		else if (idx == CFG_HEIGHT)
			scr_h = val;
	endtask

	task automatic program_screen(input logic [15:0] w, input logic [15:0] h);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || push || expected_events.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [15:0] w, h;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: key sequences through every finger count, lifts and release-all
		add_req(REQ_RELEASE, 3'd7, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_req(REQ_TOUCH, 3'd0, 1'b1, 16'd0, 16'd0, 16'd0);
		add_req(REQ_TOUCH, 3'd0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_req(REQ_TOUCH, 3'd1, 1'b1, 16'd1920, 16'd1080, 16'h8000);
		add_req(REQ_TOUCH, 3'd2, 1'b1, 16'd960, 16'd540, 16'h0001);
		add_req(REQ_TOUCH, 3'd3, 1'b1, 16'd1919, 16'd1079, 16'h7FFF);
		add_req(REQ_TOUCH, 3'd4, 1'b1, 16'd1, 16'd1, 16'h5555);
		add_req(REQ_TOUCH, 3'd5, 1'b1, 16'd100, 16'd100, 16'd100);
		add_req(REQ_TOUCH, 3'd7, 1'b0, 16'hAAAA, 16'h5555, 16'hAAAA);
		add_req(REQ_TOUCH, 3'd2, 1'b0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_TOUCH, 3'd2, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_req(REQ_TOUCH, 3'd3, 1'b0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_TOUCH, 3'd1, 1'b0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_RELEASE, 3'd0, 1'b0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_TOUCH, 3'd0, 1'b0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_TOUCH, 3'd4, 1'b1, 16'd500, 16'd500, 16'd500);
		add_req(REQ_TOUCH, 3'd4, 1'b0, 16'd0, 16'd0, 16'd0);
		add_req(REQ_TOUCH, 3'd3, 1'b1, 16'd1000, 16'd700, 16'd300);
		add_req(REQ_TOUCH, 3'd0, 1'b1, 16'd2000, 16'd2000, 16'd40000);
		add_req(REQ_RELEASE, 3'd6, 1'b1, 16'h1234, 16'h4321, 16'hBEEF);
		drain();

		// writes to an undefined index must leave the screen size alone
		write_reg(CFG_UNUSED, 16'd7);
		cfg_valid <= 1'b0;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin w = 16'd1; h = 16'd1; end
				1: begin w = 16'hFFFF; h = 16'hFFFF; end
				2: begin w = 16'd0; h = 16'd0; end
				3: begin w = 16'd640; h = 16'd480; end
				4: begin w = 16'd0; h = 16'hFFFF; end
				5, 6: begin
					w = 16'($urandom_range(1, 65535));
					h = 16'($urandom_range(1, 65535));
				end
				default: begin w = 16'd1920; h = 16'd1080; end
			endcase
			program_screen(w, h);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++)
				pending_reqs.push_back(random_req());
			drain();
		end

		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
